FILE: src/swdh_pkg.sv
`default_nettype none

package swdh_pkg;

  localparam int unsigned LINE_RESET_CLOCKS = 56;
  localparam int unsigned CNT_W = 8;

  localparam logic [7:0]  RETRY_LIMIT_RST = 8'd40;
  localparam logic [7:0]  IDLE_CYCLES_RST = 8'd8;
  localparam logic [31:0] ABORT_WORD_RST  = 32'h0000_001E;

  localparam logic [15:0] SWITCH_SEQ   = 16'hE79E;
  localparam int unsigned CONNECT_IDLE = 4;
  localparam int unsigned REQ_BITS     = 8;
  localparam int unsigned ACK_BITS     = 3;
  localparam int unsigned DATA_BITS    = 32;
  localparam int unsigned SWITCH_BITS  = 16;

  localparam logic [2:0] RESP_OK    = 3'h1;
  localparam logic [2:0] RESP_WAIT  = 3'h2;
  localparam logic [2:0] RESP_FAULT = 3'h4;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_WAIT   = 3'd1;
  localparam logic [2:0] ST_FAULT  = 3'd2;
  localparam logic [2:0] ST_PARITY = 3'd3;
  localparam logic [2:0] ST_NOACK  = 3'd4;

  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_REQ   = 4'd1;
  localparam logic [3:0] PH_TRN1  = 4'd2;
  localparam logic [3:0] PH_ACK   = 4'd3;
  localparam logic [3:0] PH_RDATA = 4'd4;
  localparam logic [3:0] PH_RPAR  = 4'd5;
  localparam logic [3:0] PH_TRN2  = 4'd6;
  localparam logic [3:0] PH_WDATA = 4'd7;
  localparam logic [3:0] PH_WPAR  = 4'd8;
  localparam logic [3:0] PH_TAIL  = 4'd9;
  localparam logic [3:0] PH_CONN  = 4'd10;

  localparam logic [1:0] CFG_RETRY_LIMIT = 2'd0;
  localparam logic [1:0] CFG_IDLE_CYCLES = 2'd1;
  localparam logic [1:0] CFG_ABORT_WORD  = 2'd2;

  localparam logic [1:0] CONN_RESET1 = 2'd0;
  localparam logic [1:0] CONN_SWITCH = 2'd1;
  localparam logic [1:0] CONN_RESET2 = 2'd2;
  localparam logic [1:0] CONN_IDLE   = 2'd3;

endpackage

`default_nettype wire

FILE: src/swd_host_transfer_engine.sv
// Serial wire debug host bit engine. Every input transaction is one SWCLK
// period: it carries the SWDIO level sampled before that rising edge and,
// when start_req_i is set and the engine is idle, a new command. Opcode 0
// runs a register transfer (request, turnaround, ACK, data and parity, idle
// clocks) with retries on WAIT and no-ack, and a DP ABORT write after FAULT.
// Opcode 1 runs the connect sequence: line reset, the JTAG-to-SWD switch
// word, a second line reset and four idle clocks.
// Every input transaction yields exactly one output transaction that tells
// the SWDIO level and direction for that clock, busy, done, the final status
// and the read word. The output is registered and appears in the cycle after the
// input is taken; while out_stall_i does not hold the output, one input is accepted
// every cycle, so the throughput is one SWCLK period per cycle. The step logic is
// combinational between the state registers and the output register.
// When the receiver raises out_stall_i, the result is held in the output
// register and in_stall_o goes high for as long as that result is not taken.
// Reset returns the engine to idle and loads the defaults: a retry limit of 40,
// 8 idle clocks and abort word 0x1E. Configuration is written through cfg_we_i,
// cfg_idx_i and cfg_wdata_i; the user writes it only while idle (not enforced).
`default_nettype none

module swd_host_transfer_engine #(
  parameter int unsigned LineResetClocks = swdh_pkg::LINE_RESET_CLOCKS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        start_req_i,
  input  wire logic        opcode_i,
  input  wire logic        ap_select_i,
  input  wire logic        read_not_write_i,
  input  wire logic [1:0]  reg_addr_i,
  input  wire logic [31:0] write_data_i,
  input  wire logic        swdio_in_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             swdio_out_o,
  output logic             swdio_drive_o,
  output logic             busy_res_o,
  output logic             done_res_o,
  output logic [2:0]       status_o,
  output logic [31:0]      read_data_o
);

  localparam int unsigned CntW = swdh_pkg::CNT_W;

  logic [7:0]  retry_limit_q;
  logic [7:0]  idle_cycles_q;
  logic [31:0] abort_word_q;

  logic [3:0]      phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [31:0]     shift_q, shift_d;
  logic            par_q, par_d;
  logic [2:0]      ack_q, ack_d;
  logic [7:0]      attempts_q, attempts_d;
  logic            cmd_op_q, cmd_op_d;
  logic            cmd_ap_q, cmd_ap_d;
  logic            cmd_rnw_q, cmd_rnw_d;
  logic [1:0]      cmd_addr_q, cmd_addr_d;
  logic [31:0]     cmd_data_q, cmd_data_d;
  logic            abort_q, abort_d;
  logic [2:0]      last_q, last_d;
  logic [1:0]      cstep_q, cstep_d;

  logic            out_valid_q;
  logic            swdio_out_q, swdio_drive_q, busy_q, done_q;
  logic [2:0]      status_q;
  logic [31:0]     rdata_q;

  logic            accept;
  logic            bit_v, drive_v, busy_v;
  logic            do_tail, do_end, do_begin, do_fin;
  logic [2:0]      fin_s;
  logic [31:0]     fin_data;
  logic [CntW:0]   cnt_inc;
  logic            cur_ap, cur_rnw;
  logic [1:0]      cur_addr;
  logic [7:0]      req_byte;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_limit_q <= swdh_pkg::RETRY_LIMIT_RST;
      idle_cycles_q <= swdh_pkg::IDLE_CYCLES_RST;
      abort_word_q  <= swdh_pkg::ABORT_WORD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        swdh_pkg::CFG_RETRY_LIMIT: retry_limit_q <= cfg_wdata_i[7:0];
        swdh_pkg::CFG_IDLE_CYCLES: idle_cycles_q <= cfg_wdata_i[7:0];
        swdh_pkg::CFG_ABORT_WORD:  abort_word_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    shift_d    = shift_q;
    par_d      = par_q;
    ack_d      = ack_q;
    attempts_d = attempts_q;
    cmd_op_d   = cmd_op_q;
    cmd_ap_d   = cmd_ap_q;
    cmd_rnw_d  = cmd_rnw_q;
    cmd_addr_d = cmd_addr_q;
    cmd_data_d = cmd_data_q;
    abort_d    = abort_q;
    last_d     = last_q;
    cstep_d    = cstep_q;
    bit_v      = 1'b0;
    drive_v    = 1'b1;
    busy_v     = 1'b1;
    do_tail    = 1'b0;
    do_end     = 1'b0;
    do_begin   = 1'b0;
    do_fin     = 1'b0;
    fin_s      = swdh_pkg::ST_OK;
    fin_data   = '0;
    cnt_inc    = {1'b0, cnt_q} + 1'b1;
    cur_ap     = 1'b0;
    cur_rnw    = 1'b0;
    cur_addr   = 2'd0;
    req_byte   = '0;

    if (phase_q == swdh_pkg::PH_IDLE) begin
      busy_v = start_req_i;
      if (start_req_i) begin
        cmd_op_d   = opcode_i;
        cmd_ap_d   = ap_select_i;
        cmd_rnw_d  = read_not_write_i;
        cmd_addr_d = reg_addr_i;
        cmd_data_d = write_data_i;
        abort_d    = 1'b0;
        attempts_d = '0;
        if (opcode_i) begin
          phase_d = swdh_pkg::PH_CONN;
          cstep_d = swdh_pkg::CONN_RESET1;
          cnt_d   = '0;
        end else begin
          phase_d = swdh_pkg::PH_REQ;
          cnt_d   = '0;
          ack_d   = '0;
          par_d   = 1'b0;
          shift_d = read_not_write_i ? 32'd0 : write_data_i;
        end
      end
    end

    cur_ap   = abort_d ? 1'b0 : cmd_ap_d;
    cur_rnw  = abort_d ? 1'b0 : cmd_rnw_d;
    cur_addr = abort_d ? 2'd0 : cmd_addr_d;
    req_byte = {1'b1, 1'b0, cur_ap ^ cur_rnw ^ cur_addr[0] ^ cur_addr[1],
                cur_addr[1], cur_addr[0], cur_rnw, cur_ap, 1'b1};
    cnt_inc  = {1'b0, cnt_d} + 1'b1;

    if (busy_v) begin
      case (phase_d)
        swdh_pkg::PH_REQ: begin
          bit_v = req_byte[cnt_d[2:0]];
          cnt_d = cnt_inc[CntW-1:0];
          if (cnt_inc >= (CntW+1)'(swdh_pkg::REQ_BITS)) begin
            phase_d = swdh_pkg::PH_TRN1;
            cnt_d   = '0;
          end
        end
        swdh_pkg::PH_TRN1: begin
          drive_v = 1'b0;
          phase_d = swdh_pkg::PH_ACK;
          cnt_d   = '0;
        end
        swdh_pkg::PH_ACK: begin
          drive_v = 1'b0;
          ack_d[cnt_d[1:0]] = ack_d[cnt_d[1:0]] | swdio_in_i;
          cnt_d = cnt_inc[CntW-1:0];
          if (cnt_inc >= (CntW+1)'(swdh_pkg::ACK_BITS)) begin
            cnt_d = '0;
            if (ack_d == swdh_pkg::RESP_OK && cur_rnw) begin
              phase_d = swdh_pkg::PH_RDATA;
              shift_d = '0;
              par_d   = 1'b0;
            end else begin
              case (ack_d)
                swdh_pkg::RESP_OK:    last_d = swdh_pkg::ST_OK;
                swdh_pkg::RESP_WAIT:  last_d = swdh_pkg::ST_WAIT;
                swdh_pkg::RESP_FAULT: last_d = swdh_pkg::ST_FAULT;
                default:              last_d = swdh_pkg::ST_NOACK;
              endcase
              phase_d = swdh_pkg::PH_TRN2;
            end
          end
        end
        swdh_pkg::PH_RDATA: begin
          drive_v = 1'b0;
          shift_d[cnt_d[4:0]] = shift_d[cnt_d[4:0]] | swdio_in_i;
          par_d = par_d ^ swdio_in_i;
          cnt_d = cnt_inc[CntW-1:0];
          if (cnt_inc >= (CntW+1)'(swdh_pkg::DATA_BITS)) begin
            phase_d = swdh_pkg::PH_RPAR;
            cnt_d   = '0;
          end
        end
        swdh_pkg::PH_RPAR: begin
          drive_v = 1'b0;
          last_d  = (swdio_in_i == par_d) ? swdh_pkg::ST_OK : swdh_pkg::ST_PARITY;
          phase_d = swdh_pkg::PH_TRN2;
        end
        swdh_pkg::PH_TRN2: begin
          drive_v = 1'b0;
          if (ack_d == swdh_pkg::RESP_OK && !cur_rnw) begin
            phase_d = swdh_pkg::PH_WDATA;
            cnt_d   = '0;
            par_d   = 1'b0;
          end else begin
            do_tail = 1'b1;
          end
        end
        swdh_pkg::PH_WDATA: begin
          bit_v   = shift_d[0];
          par_d   = par_d ^ shift_d[0];
          shift_d = {1'b0, shift_d[31:1]};
          cnt_d   = cnt_inc[CntW-1:0];
          if (cnt_inc >= (CntW+1)'(swdh_pkg::DATA_BITS)) begin
            phase_d = swdh_pkg::PH_WPAR;
            cnt_d   = '0;
          end
        end
        swdh_pkg::PH_WPAR: begin
          bit_v   = par_d;
          last_d  = swdh_pkg::ST_OK;
          do_tail = 1'b1;
        end
        swdh_pkg::PH_TAIL: begin
          cnt_d = cnt_inc[CntW-1:0];
          if (cnt_inc >= {1'b0, idle_cycles_q}) begin
            do_end = 1'b1;
          end
        end
        swdh_pkg::PH_CONN: begin
          case (cstep_d)
            swdh_pkg::CONN_RESET1, swdh_pkg::CONN_RESET2: begin
              bit_v = 1'b1;
              cnt_d = cnt_inc[CntW-1:0];
              if (cnt_inc >= (CntW+1)'(LineResetClocks)) begin
                cstep_d = cstep_d + 2'd1;
                cnt_d   = '0;
              end
            end
            swdh_pkg::CONN_SWITCH: begin
              bit_v = swdh_pkg::SWITCH_SEQ[cnt_d[3:0]];
              cnt_d = cnt_inc[CntW-1:0];
              if (cnt_inc >= (CntW+1)'(swdh_pkg::SWITCH_BITS)) begin
                cstep_d = swdh_pkg::CONN_RESET2;
                cnt_d   = '0;
              end
            end
            default: begin
              cnt_d = cnt_inc[CntW-1:0];
              if (cnt_inc >= (CntW+1)'(swdh_pkg::CONNECT_IDLE)) begin
                cstep_d = swdh_pkg::CONN_RESET1;
                do_fin  = 1'b1;
                fin_s   = swdh_pkg::ST_OK;
              end
            end
          endcase
        end
        default: begin
          phase_d = swdh_pkg::PH_IDLE;
          cnt_d   = '0;
        end
      endcase
    end

    if (do_tail) begin
      phase_d = swdh_pkg::PH_TAIL;
      cnt_d   = '0;
      if (idle_cycles_q == 8'd0) begin
        do_end = 1'b1;
      end
    end

    if (do_end) begin
      if (abort_d) begin
        abort_d = 1'b0;
        if (attempts_d >= retry_limit_q) begin
          do_fin = 1'b1;
          fin_s  = swdh_pkg::ST_FAULT;
        end else begin
          do_begin = 1'b1;
        end
      end else begin
        if (attempts_d != 8'hFF) begin
          attempts_d = attempts_d + 8'd1;
        end
        if (last_d inside {swdh_pkg::ST_OK, swdh_pkg::ST_PARITY}) begin
          do_fin = 1'b1;
          fin_s  = last_d;
        end else if (last_d == swdh_pkg::ST_FAULT) begin
          abort_d  = 1'b1;
          do_begin = 1'b1;
        end else if (attempts_d >= retry_limit_q) begin
          do_fin = 1'b1;
          fin_s  = last_d;
        end else begin
          do_begin = 1'b1;
        end
      end
    end

    if (do_begin) begin
      phase_d = swdh_pkg::PH_REQ;
      cnt_d   = '0;
      ack_d   = '0;
      par_d   = 1'b0;
      if (abort_d) begin
        shift_d = abort_word_q;
      end else if (cmd_rnw_d) begin
        shift_d = '0;
      end else begin
        shift_d = cmd_data_d;
      end
    end

    if (do_fin) begin
      phase_d = swdh_pkg::PH_IDLE;
      cnt_d   = '0;
      last_d  = fin_s;
      if (!cmd_op_d && cmd_rnw_d &&
          (fin_s == swdh_pkg::ST_OK || fin_s == swdh_pkg::ST_PARITY)) begin
        fin_data = shift_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= swdh_pkg::PH_IDLE;
      cnt_q      <= '0;
      shift_q    <= '0;
      par_q      <= 1'b0;
      ack_q      <= '0;
      attempts_q <= '0;
      cmd_op_q   <= 1'b0;
      cmd_ap_q   <= 1'b0;
      cmd_rnw_q  <= 1'b0;
      cmd_addr_q <= '0;
      cmd_data_q <= '0;
      abort_q    <= 1'b0;
      last_q     <= swdh_pkg::ST_OK;
      cstep_q    <= swdh_pkg::CONN_RESET1;
    end else if (accept) begin
      phase_q    <= phase_d;
      cnt_q      <= cnt_d;
      shift_q    <= shift_d;
      par_q      <= par_d;
      ack_q      <= ack_d;
      attempts_q <= attempts_d;
      cmd_op_q   <= cmd_op_d;
      cmd_ap_q   <= cmd_ap_d;
      cmd_rnw_q  <= cmd_rnw_d;
      cmd_addr_q <= cmd_addr_d;
      cmd_data_q <= cmd_data_d;
      abort_q    <= abort_d;
      last_q     <= last_d;
      cstep_q    <= cstep_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      swdio_out_q   <= drive_v & bit_v & busy_v;
      swdio_drive_q <= drive_v;
      busy_q        <= busy_v;
      done_q        <= do_fin;
      status_q      <= do_fin ? fin_s : swdh_pkg::ST_OK;
      rdata_q       <= fin_data;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign swdio_out_o   = swdio_out_q;
  assign swdio_drive_o = swdio_drive_q;
  assign busy_res_o    = busy_q;
  assign done_res_o    = done_q;
  assign status_o      = status_q;
  assign read_data_o   = rdata_q;

endmodule

`default_nettype wire
